// File: rtl/dsrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsrt_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  typedef logic [KEY_W-1:0] date_key_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               last;
  } date_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic               out_last;
    logic               overflow;
  } date_out_t;

  // date moving right through the chain
  typedef struct packed {
    logic      valid;
    date_key_t key;
  } carry_t;

  // date held in a cell, seen by its left neighbor
  typedef struct packed {
    logic      occ;
    date_key_t key;
  } slot_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  function automatic date_key_t pack_key(input date_in_t d);
    return {d.year, d.month, d.day};
  endfunction

endpackage
`default_nettype wire

// File: rtl/dsrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dsrt_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire dsrt_pkg::carry_t carry_i,
  input  wire dsrt_pkg::slot_t  nbr_i,
  output dsrt_pkg::carry_t      carry_o,
  output dsrt_pkg::slot_t       slot_o
);

  logic                occ_r, occ_nxt;
  dsrt_pkg::date_key_t key_r, key_nxt;
  logic                cv_r, cv_nxt;
  dsrt_pkg::date_key_t ck_r, ck_nxt;

  always_comb begin
    occ_nxt = occ_r;
    key_nxt = key_r;
    cv_nxt  = 1'b0;
    ck_nxt  = ck_r;
    if (shift) begin
      // take the right neighbor's date
      occ_nxt = nbr_i.occ;
      key_nxt = nbr_i.key;
    end else if (carry_i.valid) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        key_nxt = carry_i.key;
      end else if (carry_i.key < key_r) begin
        // keep the smaller, pass the held date on
        key_nxt = carry_i.key;
        cv_nxt  = 1'b1;
        ck_nxt  = key_r;
      end else begin
        cv_nxt = 1'b1;
        ck_nxt = carry_i.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      cv_r  <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      cv_r  <= cv_nxt;
    end
    key_r <= key_nxt;
    ck_r  <= ck_nxt;
  end

  assign carry_o = '{valid: cv_r, key: ck_r};
  assign slot_o  = '{occ: occ_r, key: key_r};

endmodule
`default_nettype wire

// File: rtl/date_sorter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Insertion sorter on a chain of MAX_ITEMS compare-and-keep cells.
// Load: one date per cycle; each date ripples right one cell per cycle.
// After the last date the chain settles in the drain state, then one sorted
// date per cycle leaves cell 0 while out_stall is low.
// Inputs stall from the last transfer until the final result is taken.
// Reset (synchronous, active low) empties every cell and clears count/overflow.
module date_sorter_core #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dsrt_pkg::date_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dsrt_pkg::date_out_t     out_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  dsrt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    drain_r, drain_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_xfer, out_xfer, full, insert, shift;
  dsrt_pkg::carry_t carry [MAX_ITEMS+1];
  dsrt_pkg::slot_t  slot  [MAX_ITEMS+1];

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign full     = (count_r == CW'(MAX_ITEMS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsrt_pkg::ST_LOAD:  if (in_xfer && in_data.last) state_nxt = dsrt_pkg::ST_DRAIN;
      dsrt_pkg::ST_DRAIN: if (drain_r == CW'(1)) state_nxt = dsrt_pkg::ST_EMIT;
      dsrt_pkg::ST_EMIT:  if (out_xfer && count_r == CW'(1)) state_nxt = dsrt_pkg::ST_LOAD;
      default:            state_nxt = dsrt_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      dsrt_pkg::ST_LOAD:  in_stall  = 1'b0;
      dsrt_pkg::ST_DRAIN: in_stall  = 1'b1;
      dsrt_pkg::ST_EMIT:  out_valid = 1'b1;
      default:            in_stall  = 1'b1;
    endcase
  end

  assign insert = in_xfer && !full;
  assign shift  = out_xfer;

  always_comb begin
    count_nxt = count_r;
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (insert) count_nxt = count_r + CW'(1);
    if (in_xfer && full) ovf_nxt = 1'b1;
    if (in_xfer && in_data.last) drain_nxt = CW'(MAX_ITEMS);
    else if (state_r == dsrt_pkg::ST_DRAIN) drain_nxt = drain_r - CW'(1);
    if (out_xfer) begin
      count_nxt = count_r - CW'(1);
      // end of run: clear overflow for the next set
      if (count_r == CW'(1)) ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsrt_pkg::ST_LOAD;
      count_r <= '0;
      drain_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign carry[0]         = '{valid: insert, key: dsrt_pkg::pack_key(in_data)};
  assign slot[MAX_ITEMS]  = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    dsrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (shift),
      .carry_i (carry[i]),
      .nbr_i   (slot[i+1]),
      .carry_o (carry[i+1]),
      .slot_o  (slot[i])
    );
  end

  assign out_data.out_year  = slot[0].key[dsrt_pkg::KEY_W-1 -: dsrt_pkg::YEAR_W];
  assign out_data.out_month = slot[0].key[dsrt_pkg::DAY_W +: dsrt_pkg::MONTH_W];
  assign out_data.out_day   = slot[0].key[dsrt_pkg::DAY_W-1:0];
  assign out_data.out_last  = (count_r == CW'(1));
  assign out_data.overflow  = ovf_r;

endmodule
`default_nettype wire

// File: rtl/dsrt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dsrt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire dsrt_pkg::date_in_t in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dsrt_pkg::date_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no input transfer while a run is being emitted
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during output run");

  // run ends after the final result transfer
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.out_last |=> !out_valid)
    else $error("result after final of run");

  // overflow is constant across one run
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.out_last |=>
      out_valid && out_data.overflow == $past(out_data.overflow))
    else $error("overflow changed within run");

  // a transfer with last closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input open after last date");

endmodule

bind date_sorter_core dsrt_checker u_dsrt_checker (.*);
`default_nettype wire
